// File: hw/rtl/lrt_pkg.sv
// Package for the LRU replacement tracker.
// Holds sizes, field widths, codes and the result struct; no dependencies.
package lrt_pkg;

    localparam int NUM_KEYS  = 26;
    localparam int KEY_W     = 5;
    localparam int CAP_W     = 5;
    localparam int ADDR_W    = $clog2(NUM_KEYS);
    localparam int OCC_W     = $clog2(NUM_KEYS + 1);
    localparam int CAP_RESET = 26;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key_res;
        logic             empty_res;
        logic             last;
    } t_result;

endpackage

// File: hw/rtl/lrt_in_if.sv
// Request channel of the LRU replacement tracker: valid/ready plus payload.
// Depends on lrt_pkg for field widths.
interface lrt_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [lrt_pkg::KEY_W-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink (input valid, input kind, input key, output ready);
endinterface

// File: hw/rtl/lrt_out_if.sv
// Result channel of the LRU replacement tracker: valid/ready plus payload.
// Depends on lrt_pkg for field widths.
interface lrt_out_if;
    logic                      valid;
    logic                      ready;
    logic [lrt_pkg::KEY_W-1:0] key_res;
    logic                      empty_res;
    logic                      last;

    modport source (output valid, output key_res, output empty_res, output last,
                    input ready);
    modport sink (input valid, input key_res, input empty_res, input last,
                  output ready);
endinterface

// File: hw/rtl/lrt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lrt_out_reg.sv
// Output register of the LRU replacement tracker: holds one result until transfer.
// Depends on lrt_pkg and lrt_out_if.
module lrt_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lrt_pkg::t_result i_res,
    output logic             o_free,
    lrt_out_if.source        o_out
);
    import lrt_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.key_res   = r_res.key_res;
    assign o_out.empty_res = r_res.empty_res;
    assign o_out.last      = r_res.last;

`ifndef SYNTHESIS
    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded while output register is held");
`endif

endmodule

// File: hw/rtl/lru_replacement_tracker.sv
// LRU replacement tracker: a fully associative cache of up to NUM_KEYS keys.
// Usage:
//   i_in (valid/ready) carries requests: kind access with a key, or kind dump.
//   o_out (valid/ready) carries dump results, least recently used key first,
//   last set on the final one; an empty cache dumps one result with empty_res.
//   i_cfg_we/i_cfg_wdata write the capacity (0 acts as 1, above NUM_KEYS
//   saturates); write it only while the block is idle.
// Timing:
//   A miss with room writes the key on top as it is taken. A hit reads the
//   key's rank and then moves every more recent key down one place, one entry
//   per cycle through the order memory, then writes the key on top; a key
//   already most recent moves nothing. A miss on a full cache reads the oldest
//   key, shifts the rest and writes the new key on top.
//   A dump reads one rank per cycle while the receiver does not stall; each
//   result passes the order memory's read register and the output register.
//   The single read and write port of the order memory sets this pace.
// Reset clears presence bits and occupancy and sets capacity to NUM_KEYS; the
// memories are not cleared. A result is held in an output register while the
// receiver stalls; a dump then pauses, and no request is taken until it ends.
module lru_replacement_tracker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lrt_pkg::CAP_W-1:0] i_cfg_wdata,
    lrt_in_if.sink                    i_in,
    lrt_out_if.source                 o_out
);
    import lrt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HRANK = 3'd1;
    localparam logic [2:0] S_EVICT = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_DOUT  = 3'd5;
    localparam logic [2:0] S_EMPTY = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [NUM_KEYS-1:0] r_present, n_present;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [CAP_W-1:0]    r_capacity;

    // order memory: rank -> key
    logic              a_we, a_re;
    logic [ADDR_W-1:0] a_waddr, a_raddr;
    logic [KEY_W-1:0]  a_wdata, a_rdata;
    // rank memory: key -> rank
    logic              b_we, b_re;
    logic [ADDR_W-1:0] b_waddr, b_raddr;
    logic [ADDR_W-1:0] b_wdata, b_rdata;

    logic             w_in_acc;
    logic             w_key_ok;
    logic [OCC_W-1:0] w_eff_cap;
    logic [OCC_W-1:0] w_idx_inc;
    logic [OCC_W-1:0] w_rank_inc;
    logic [OCC_W-1:0] w_occ_dec;
    logic             w_dump_last;
    logic             w_out_free;
    logic             w_out_load;
    t_result          w_out_res;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_key_ok   = (OCC_W'(i_in.key) < OCC_W'(NUM_KEYS));

    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = OCC_W'(1);
        end else if (OCC_W'(r_capacity) > OCC_W'(NUM_KEYS)) begin
            w_eff_cap = OCC_W'(NUM_KEYS);
        end else begin
            w_eff_cap = OCC_W'(r_capacity);
        end
    end

    assign w_idx_inc   = OCC_W'(r_idx) + OCC_W'(1);
    assign w_rank_inc  = OCC_W'(b_rdata) + OCC_W'(1);
    assign w_occ_dec   = r_occ - OCC_W'(1);
    assign w_dump_last = (w_idx_inc == r_occ);

    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_present  = r_present;
        n_idx      = r_idx;
        n_key      = r_key;
        a_we       = 1'b0;
        a_waddr    = '0;
        a_wdata    = '0;
        a_re       = 1'b0;
        a_raddr    = '0;
        b_we       = 1'b0;
        b_waddr    = '0;
        b_wdata    = '0;
        b_re       = 1'b0;
        b_raddr    = '0;
        w_out_load = 1'b0;
        w_out_res  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_key = i_in.key;
                    if (i_in.kind == KIND_DUMP) begin
                        n_idx = '0;
                        if (r_occ == '0) begin
                            n_state = S_EMPTY;
                        end else begin
                            a_re    = 1'b1;
                            a_raddr = '0;
                            n_state = S_DOUT;
                        end
                    end else if (w_key_ok) begin
                        if (r_present[i_in.key[ADDR_W-1:0]]) begin
                            b_re    = 1'b1;
                            b_raddr = i_in.key[ADDR_W-1:0];
                            n_state = S_HRANK;
                        end else if (r_occ < w_eff_cap) begin
                            // insert on top while there is room
                            a_we    = 1'b1;
                            a_waddr = r_occ[ADDR_W-1:0];
                            a_wdata = i_in.key;
                            b_we    = 1'b1;
                            b_waddr = i_in.key[ADDR_W-1:0];
                            b_wdata = r_occ[ADDR_W-1:0];
                            n_present[i_in.key[ADDR_W-1:0]] = 1'b1;
                            n_occ   = r_occ + OCC_W'(1);
                        end else begin
                            a_re    = 1'b1;
                            a_raddr = '0;
                            n_state = S_EVICT;
                        end
                    end
                end
            end
            S_HRANK: begin
                // already most recent: nothing moves; else fetch the next more recent entry
                if (w_rank_inc < r_occ) begin
                    a_re    = 1'b1;
                    a_raddr = w_rank_inc[ADDR_W-1:0];
                    n_idx   = w_rank_inc[ADDR_W-1:0];
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EVICT: begin
                n_present[a_rdata[ADDR_W-1:0]] = 1'b0;
                if (r_occ > OCC_W'(1)) begin
                    a_re    = 1'b1;
                    a_raddr = ADDR_W'(1);
                    n_idx   = ADDR_W'(1);
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_SHIFT: begin
                // move the entry read last cycle down one rank, fetch the next
                a_we    = 1'b1;
                a_waddr = r_idx - ADDR_W'(1);
                a_wdata = a_rdata;
                b_we    = 1'b1;
                b_waddr = a_rdata[ADDR_W-1:0];
                b_wdata = r_idx - ADDR_W'(1);
                if (w_idx_inc < r_occ) begin
                    a_re    = 1'b1;
                    a_raddr = w_idx_inc[ADDR_W-1:0];
                    n_idx   = w_idx_inc[ADDR_W-1:0];
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                a_we    = 1'b1;
                a_waddr = w_occ_dec[ADDR_W-1:0];
                a_wdata = r_key;
                b_we    = 1'b1;
                b_waddr = r_key[ADDR_W-1:0];
                b_wdata = w_occ_dec[ADDR_W-1:0];
                n_present[r_key[ADDR_W-1:0]] = 1'b1;
                n_state = S_IDLE;
            end
            S_DOUT: begin
                if (w_out_free) begin
                    w_out_load          = 1'b1;
                    w_out_res.key_res   = a_rdata;
                    w_out_res.empty_res = 1'b0;
                    w_out_res.last      = w_dump_last;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        a_re    = 1'b1;
                        a_raddr = w_idx_inc[ADDR_W-1:0];
                        n_idx   = w_idx_inc[ADDR_W-1:0];
                    end
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    w_out_load          = 1'b1;
                    w_out_res.key_res   = '0;
                    w_out_res.empty_res = 1'b1;
                    w_out_res.last      = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_present  <= '0;
            r_capacity <= CAP_W'(CAP_RESET);
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_present <= n_present;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
    end

    lrt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NUM_KEYS)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    lrt_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_KEYS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    lrt_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_res   (w_out_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    ap_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_present) == int'(r_occ)))
        else $error("presence bits disagree with occupancy");

    ap_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(NUM_KEYS))
        else $error("occupancy above key count");

    ap_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_idx != '0 && OCC_W'(r_idx) < r_occ))
        else $error("shift index out of range");

    ap_hit_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.kind == KIND_ACCESS && w_key_ok &&
         r_present[i_in.key[ADDR_W-1:0]]) |=> (r_state == S_HRANK))
        else $error("hit did not read its rank");

    ap_dump_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUT && w_out_free) |=> o_out.valid)
        else $error("dump step produced no result");
`endif

endmodule
